>>> rtl/core/npc_pkg.sv
`timescale 1ns / 1ps
// Package for the nearest palette color block: sizes, codes and shared types.
// Used by every module under rtl/core but npc_ram; depends on nothing else.
package npc_pkg;

  // Item and field widths.
  localparam int ChanW  = 8;
  localparam int RgbW   = 3 * ChanW;
  localparam int IdxW   = 8;
  localparam int DistW  = 18;
  localparam int SizeW  = 9;

  // Palette storage is split across a row of cells, each owning a block of entries.
  localparam int PaletteDepth = 256;
  localparam int NumCells     = 8;
  localparam int CellDepth    = PaletteDepth / NumCells;
  localparam int CellAw       = $clog2(CellDepth);
  localparam int CellIdW      = $clog2(NumCells);

  // Distance above any real one (3 * 256 * 256), and the largest real distance.
  localparam logic [DistW-1:0] DistInf = DistW'(3 * 256 * 256);
  localparam logic [DistW-1:0] DistMax = DistW'(3 * 255 * 255);

  // Opcodes carried in tuser.
  localparam logic OpWrite  = 1'b0;
  localparam logic OpLookup = 1'b1;

  // Running best candidate.
  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [IdxW-1:0]  idx;
  } best_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic              wr_en;
    logic [IdxW-1:0]   wr_addr;
    logic [RgbW-1:0]   wr_data;
    logic              rd_en;
    logic [CellAw-1:0] rd_addr;
    logic              cmp_vld;
    logic [CellAw-1:0] cmp_addr;
    logic              clear;
    logic              drain;
    logic [SizeW-1:0]  count;
    logic [RgbW-1:0]   query;
  } ctrl_t;

endpackage

>>> rtl/core/npc_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read data.
// Stand-alone; no package needed.
module npc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/npc_cell.sv
`timescale 1ns / 1ps
// One cell of the palette row: a block of entries, a distance unit, a local best
// and a link register toward the next cell. Depends on npc_pkg and npc_ram.
module npc_cell
  import npc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CellIdW-1:0] cell_id_i,
  input  ctrl_t              ctrl_i,
  input  best_t              prev_i,
  output best_t              next_o
);

  logic              wr_sel;
  logic [RgbW-1:0]   entry;
  logic [ChanW-1:0]  dr, dg, db;
  logic [DistW-1:0]  dist_d, dist_q;
  logic [IdxW-1:0]   cand_idx;
  logic              cand_en;
  best_t             local_q;
  best_t             link_q;

  // Entries of this cell: the upper index bits select the cell.
  assign wr_sel = ctrl_i.wr_en && (ctrl_i.wr_addr[IdxW-1 -: CellIdW] == cell_id_i);

  npc_ram #(
    .WIDTH(RgbW),
    .DEPTH(CellDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_sel),
    .waddr_i (ctrl_i.wr_addr[CellAw-1:0]),
    .wdata_i (ctrl_i.wr_data),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (ctrl_i.rd_addr),
    .rdata_o (entry)
  );

  // Absolute channel differences and the sum of their squares.
  always_comb begin
    dr = (entry[23:16] > ctrl_i.query[23:16]) ? entry[23:16] - ctrl_i.query[23:16]
                                              : ctrl_i.query[23:16] - entry[23:16];
    dg = (entry[15:8] > ctrl_i.query[15:8]) ? entry[15:8] - ctrl_i.query[15:8]
                                            : ctrl_i.query[15:8] - entry[15:8];
    db = (entry[7:0] > ctrl_i.query[7:0]) ? entry[7:0] - ctrl_i.query[7:0]
                                          : ctrl_i.query[7:0] - entry[7:0];
    dist_d = DistW'(dr) * DistW'(dr) + DistW'(dg) * DistW'(dg) + DistW'(db) * DistW'(db);
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  // The compared entry takes part only if its index is below the palette size.
  assign cand_idx = {cell_id_i, ctrl_i.cmp_addr};
  assign cand_en  = {1'b0, cand_idx} < ctrl_i.count;

  // Local best over this cell's entries; strict less keeps the lowest index on ties.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q <= '{distance: DistInf, idx: '0};
    end else if (ctrl_i.clear) begin
      local_q <= '{distance: DistInf, idx: '0};
    end else if (ctrl_i.cmp_vld && cand_en && (dist_q < local_q.distance)) begin
      local_q <= '{distance: dist_q, idx: cand_idx};
    end
  end

  // Link toward the next cell; the lower-index side wins ties.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '{distance: DistInf, idx: '0};
    end else if (ctrl_i.clear) begin
      link_q <= '{distance: DistInf, idx: '0};
    end else if (ctrl_i.drain) begin
      link_q <= (prev_i.distance <= local_q.distance) ? prev_i : local_q;
    end
  end

  assign next_o = link_q;

endmodule

>>> rtl/core/npc_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the palette row: input handshake, palette size register, address
// sweep, drain of the cell chain and the output register. Depends on npc_pkg.
module npc_ctrl
  import npc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,
  input  best_t            tail_i,
  output ctrl_t            ctrl_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSweep = 3'd1;
  localparam logic [2:0] StFlush = 3'd2;
  localparam logic [2:0] StDrain = 3'd3;
  localparam logic [2:0] StLoad  = 3'd4;

  localparam logic [CellAw-1:0] LastAddr  = CellAw'(CellDepth - 1);
  localparam logic [CellAw-1:0] LastDrain = CellAw'(NumCells - 1);
  localparam logic [SizeW-1:0]  SizeMax   = SizeW'(PaletteDepth);

  logic [2:0]        state_d, state_q;
  logic [CellAw-1:0] cnt_d, cnt_q;
  logic [SizeW-1:0]  size_q;
  logic [SizeW-1:0]  count;
  logic [RgbW-1:0]   query_q;
  logic              rd_vld_q, cmp_vld_q;
  logic [CellAw-1:0] rd_addr_q, cmp_addr_q;
  logic              accept, start, load;
  logic              out_vld_q;
  best_t             out_q;

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign start         = accept && (s_axis_tuser == OpLookup);
  assign load          = (state_q == StLoad) && (!out_vld_q || m_axis_tready);

  // Palette size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeMax;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // Zero searches entry 0 alone; anything past the store saturates.
  always_comb begin
    if (size_q == '0) begin
      count = SizeW'(1);
    end else if (size_q > SizeMax) begin
      count = SizeMax;
    end else begin
      count = size_q;
    end
  end

  // Query pixel is held for the whole search.
  always_ff @(posedge clk_i) begin
    if (start) begin
      query_q <= s_axis_tdata[31:8];
    end
  end

  // Sequencer: sweep the cell addresses, let the distance pipe empty, drain the chain.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StSweep;
          cnt_d   = '0;
        end
      end
      StSweep: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastAddr) begin
          state_d = StFlush;
          cnt_d   = '0;
        end
      end
      StFlush: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[0]) begin
          state_d = StDrain;
          cnt_d   = '0;
        end
      end
      StDrain: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastDrain) begin
          state_d = StLoad;
          cnt_d   = '0;
        end
      end
      StLoad: begin
        if (load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Read-to-compare tag pipeline: RAM read register, then distance register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= (state_q == StSweep);
      cmp_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q  <= cnt_q;
    cmp_addr_q <= rd_addr_q;
  end

  // Broadcast to the cells.
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.wr_en    = accept && (s_axis_tuser == OpWrite);
    ctrl_o.wr_addr  = s_axis_tdata[7:0];
    ctrl_o.wr_data  = s_axis_tdata[31:8];
    ctrl_o.rd_en    = (state_q == StSweep);
    ctrl_o.rd_addr  = cnt_q;
    ctrl_o.cmp_vld  = cmp_vld_q;
    ctrl_o.cmp_addr = cmp_addr_q;
    ctrl_o.clear    = start;
    ctrl_o.drain    = (state_q == StDrain);
    ctrl_o.count    = count;
    ctrl_o.query    = query_q;
  end

  // Output register: holds a finished word until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= tail_i;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_q.distance, out_q.idx};

endmodule

>>> rtl/core/nearest_palette_color_top.sv
`timescale 1ns / 1ps
// Top level of the nearest palette color block: sequencer plus a row of cells.
// Depends on npc_pkg, npc_ctrl, npc_cell and npc_ram.
//
// Usage:
//   Input words arrive on s_axis; tuser carries the opcode (write or lookup).
//   A write stores one 24-bit RGB entry at entry_index and yields no output;
//   writes can stream back to back.
//   A lookup searches the first palette_size entries (at least one) for
//   the least squared distance and returns one word on m_axis with
//   best_index and best_distance, lowest index on ties.
//   The 256 entries sit in 8 cells of 32 each. A lookup sweeps the 32
//   addresses of every cell in parallel, waits for the read and distance
//   registers, then passes the cell bests down the chain and loads the
//   output register; the input is ready again in the same cycle that the
//   result becomes valid.
//   The output register lets new words in while a result waits; a second
//   lookup holds its result at the chain tail until the first is taken.
//   The user writes palette_size through cfg_we_i/cfg_wdata_i only while
//   idle; the block does not enforce it. Reset clears control state and
//   sets palette_size to 256; palette contents are undefined until written.
module nearest_palette_color_top
  import npc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue
  input  logic [31:0]      s_axis_tdata,
  // [0] opcode
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [7:0] best_index, [25:8] best_distance, [31:26] zero
  output logic [31:0]      m_axis_tdata,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i
);

  ctrl_t ctrl;
  best_t link [NumCells+1];

  npc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .tail_i        (link[NumCells]),
    .ctrl_o        (ctrl)
  );

  // Head of the chain sees no candidate.
  assign link[0] = '{distance: DistInf, idx: '0};

  // Row of cells, each handing its best to the next.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    npc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (CellIdW'(k)),
      .ctrl_i    (ctrl),
      .prev_i    (link[k]),
      .next_o    (link[k+1])
    );
  end

  // A delivered distance is always a real one, never the empty marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[25:8] <= DistMax))
    else $error("output distance out of range");

  // No input word is taken while a search or drain is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !ctrl.rd_en && !ctrl.cmp_vld && !ctrl.drain)
    else $error("input ready during a search");

  // An accepted lookup closes the input for the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OpLookup)) |=> !s_axis_tready)
    else $error("input still ready after a lookup");

  // Palette writes never overlap a sweep read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.wr_en |-> !ctrl.rd_en)
    else $error("palette write during a sweep");

endmodule

>>> tb/sv/npc_nearest_check.sv
`timescale 1ns / 1ps
// Checker for the nearest palette color block: mirrors the palette and the size register,
// predicts the nearest entry for every lookup word and compares it with the output words.
// Depends on npc_pkg; instantiated by tb beside the block.
module npc_nearest_check
  import npc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  input  logic             s_tready_i,
  input  logic [31:0]      s_tdata_i,
  input  logic             s_tuser_i,
  input  logic             m_tvalid_i,
  input  logic             m_tready_i,
  input  logic [31:0]      m_tdata_i,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,
  output int               err_count_o,
  output int               pending_o
);

  // Mirror of the palette (red 23:16, green 15:8, blue 7:0) and of palette_size.
  logic [RgbW-1:0]  shade_mirror [PaletteDepth];
  logic [SizeW-1:0] size_mirror;

  // Nearest entries still owed by the block, oldest first.
  best_t nearest_q [$];

  // Searches the active part of the mirrored palette; the first entry wins a tie.
  function automatic best_t nearest_entry(input logic [ChanW-1:0] red,
                                          input logic [ChanW-1:0] green,
                                          input logic [ChanW-1:0] blue);
    int    span;
    int    j;
    int    dr;
    int    dg;
    int    db;
    int    sq_dist;
    int    least;
    best_t best;
    // A size of zero still searches entry 0; oversized values saturate.
    span = int'(size_mirror);
    if (span == 0) span = 1;
    if (span > PaletteDepth) span = PaletteDepth;
    least = int'(DistInf);
    best.idx = '0;
    for (j = 0; j < span; j++) begin
      dr = int'(red) - int'(shade_mirror[j][23:16]);
      dg = int'(green) - int'(shade_mirror[j][15:8]);
      db = int'(blue) - int'(shade_mirror[j][7:0]);
      sq_dist = dr * dr + dg * dg + db * db;
      if (sq_dist < least) begin
        least = sq_dist;
        best.idx = IdxW'(j);
      end
    end
    best.distance = DistW'(least);
    return best;
  endfunction

  // Watch all three channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    best_t            want;
    best_t            seen;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    if (!rst_ni) begin
      size_mirror = SizeW'(PaletteDepth);
      nearest_q.delete();
      err_count_o = 0;
      pending_o = 0;
    end else begin
      // Output word: compare with the oldest prediction.
      if (m_tvalid_i && m_tready_i) begin
        seen.idx = m_tdata_i[7:0];
        seen.distance = m_tdata_i[25:8];
        if (nearest_q.size() == 0) begin
          $error("unexpected output word: best_index %0d, best_distance %0d",
                 seen.idx, seen.distance);
          err_count_o++;
        end else begin
          want = nearest_q.pop_front();
          if (seen.idx !== want.idx) begin
            $error("best_index: expected %0d, actual %0d", want.idx, seen.idx);
            err_count_o++;
          end
          if (seen.distance !== want.distance) begin
            $error("best_distance: expected %0d, actual %0d", want.distance,
                   seen.distance);
            err_count_o++;
          end
        end
      end
      // Input word: a write updates the mirror, a lookup adds a prediction.
      if (s_tvalid_i && s_tready_i) begin
        red = s_tdata_i[15:8];
        green = s_tdata_i[23:16];
        blue = s_tdata_i[31:24];
        if (s_tuser_i == OpWrite) begin
          shade_mirror[s_tdata_i[7:0]] = {red, green, blue};
        end else begin
          nearest_q.push_back(nearest_entry(red, green, blue));
        end
      end
      if (cfg_we_i) begin
        size_mirror = cfg_wdata_i;
      end
      pending_o = nearest_q.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the nearest palette color block: clock, reset, stimulus and verdict.
// Depends on npc_pkg, nearest_palette_color_top and npc_nearest_check.
module tb;
  import npc_pkg::*;

  localparam int StallMax      = 18;
  localparam int SettleCycles  = 60;
  localparam int WatchdogLimit = 2000;
  localparam int ItemTarget    = 950;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [31:0]      m_axis_tdata;
  logic             cfg_we_i = 1'b0;
  logic [SizeW-1:0] cfg_wdata_i = '0;

  int err_count;
  int pending;
  int idle_cycles = 0;

  // Stimulus-side record of what has been written, used to aim lookups and make ties.
  logic [RgbW-1:0] shade [PaletteDepth];
  bit              filled [PaletteDepth];
  int              span = PaletteDepth;
  int              sent = 0;
  bit              steady = 1'b0;

  always #5 clk_i = ~clk_i;

  nearest_palette_color_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  npc_nearest_check checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // Watchdog: ends the run when no word moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stalls a random number of cycles before taking each output word.
  initial begin : receiver
    int stall;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      stall = steady ? 0 : $urandom_range(0, StallMax);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Each channel either all zeros or all ones.
  function automatic logic [RgbW-1:0] corner_shade();
    return {$urandom_range(0, 1) ? 8'hFF : 8'h00,
            $urandom_range(0, 1) ? 8'hFF : 8'h00,
            $urandom_range(0, 1) ? 8'hFF : 8'h00};
  endfunction

  // Color for a palette write; copies of earlier entries create ties.
  function automatic logic [RgbW-1:0] pick_shade();
    int unsigned k;
    int unsigned j;
    k = $urandom_range(0, 9);
    j = $urandom_range(0, PaletteDepth - 1);
    if (k < 3 && filled[j]) return shade[j];
    if (k < 5) return corner_shade();
    return RgbW'($urandom());
  endfunction

  // Pixel for a lookup: exact hits, near misses, corners or anything.
  function automatic logic [RgbW-1:0] pick_pixel();
    logic [RgbW-1:0] base;
    int unsigned     k;
    base = shade[$urandom_range(0, span - 1)];
    k = $urandom_range(0, 9);
    if (k < 3) return base;
    if (k < 5) return base ^ (RgbW'($urandom()) & 24'h070707);
    if (k < 6) return corner_shade();
    return RgbW'($urandom());
  endfunction

  // Sends one word after a random gap; returns at the falling edge after acceptance.
  task automatic send_word(input logic op, input logic [IdxW-1:0] idx,
                           input logic [RgbW-1:0] rgb);
    int gap;
    gap = steady ? 0 : $urandom_range(0, StallMax);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata <= {rgb[7:0], rgb[15:8], rgb[23:16], idx};
    s_axis_tuser <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OpWrite) begin
      shade[idx] = rgb;
      filled[idx] = 1'b1;
    end
    sent++;
    @(negedge clk_i);
  endtask

  // Holds the sender off until every predicted result has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // Writes palette_size while the block is idle.
  task automatic write_size(input logic [SizeW-1:0] size);
    drain_results();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= size;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    span = (size == 0) ? 1 : (int'(size) > PaletteDepth) ? PaletteDepth : int'(size);
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    int seg;
    int seg_len;
    int n;
    logic [SizeW-1:0] size;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Zero size: entry 0 alone is searched.
    write_size('0);
    send_word(OpWrite, 8'd0, 24'h000000);
    send_word(OpLookup, 8'hFF, 24'hFFFFFF);
    send_word(OpLookup, 8'h00, 24'h000000);
    send_word(OpWrite, 8'd255, 24'hFFFFFF);
    send_word(OpWrite, 8'd1, 24'hFFFFFF);
    // Entry 1 is closer but lies outside the searched range.
    send_word(OpLookup, 8'h5A, 24'hF0F0F0);

    // Two entries: nearest, then a tie that the lower index wins.
    write_size(SizeW'(2));
    send_word(OpLookup, 8'hA5, 24'hF0F0F0);
    send_word(OpWrite, 8'd1, 24'h000000);
    send_word(OpLookup, 8'h33, 24'h102030);
    send_word(OpWrite, 8'd0, 24'hFF00FF);
    send_word(OpWrite, 8'd1, 24'hFF00FF);
    send_word(OpLookup, 8'hCC, 24'h00FF00);

    // Fill the rest of the palette so any size can be searched.
    for (n = 0; n < PaletteDepth; n++) begin
      if (!filled[n]) send_word(OpWrite, IdxW'(n), pick_shade());
    end

    // Random segments, each with its own size; the first few take the extremes.
    seg = 0;
    while (sent < ItemTarget) begin
      case (seg)
        0: size = SizeW'(511);
        1: size = SizeW'(PaletteDepth);
        2: size = SizeW'(1);
        3: size = '0;
        default: begin
          case ($urandom_range(0, 7))
            0: size = '0;
            1: size = SizeW'(1);
            2: size = SizeW'(PaletteDepth);
            3: size = SizeW'(511);
            4: size = SizeW'($urandom_range(257, 510));
            5, 6: size = SizeW'($urandom_range(2, 16));
            default: size = SizeW'($urandom_range(17, 255));
          endcase
        end
      endcase
      write_size(size);
      steady = ($urandom_range(0, 3) == 0);
      seg_len = $urandom_range(30, 80);
      for (n = 0; n < seg_len; n++) begin
        if ($urandom_range(0, 39) == 0) drain_results();
        if ($urandom_range(0, 1) == 0) begin
          send_word(OpWrite, IdxW'($urandom()), pick_shade());
        end else begin
          send_word(OpLookup, IdxW'($urandom()), pick_pixel());
        end
      end
      seg++;
    end

    // Let the last results come out, then give the verdict.
    drain_results();
    repeat (SettleCycles) @(negedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
